### src/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation block.
package bsc_pkg;

   localparam int unsigned RAW_W    = 24;
   localparam int unsigned OUT_W    = 24;
   localparam int unsigned CSR_W    = 64;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned LIMB_W   = 32;

   // pipeline widths of the fixed-point datapath
   localparam int unsigned TN_W     = 61;
   localparam int unsigned H3_W     = 34;
   localparam int unsigned H2_W     = 96;
   localparam int unsigned H1_W     = 158;
   localparam int unsigned H0_W     = 220;
   localparam int unsigned B2_W     = 34;
   localparam int unsigned B1_W     = 62;
   localparam int unsigned B0_W     = 89;

   // scaling shifts of the Horner coefficients
   localparam int unsigned B2_SHIFT = 53;
   localparam int unsigned B1_SHIFT = 85;
   localparam int unsigned B0_SHIFT = 116;
   localparam int unsigned P_FRAC   = 175;

   // cycles from an accepted request to its response strobe
   localparam int unsigned LATENCY  = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_TEMP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_PRESS_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_PRESS_B = 2'd2;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] temperature_q16;
      logic [OUT_W-1:0]        pressure_q6;
      logic                    saturated;
   } rsp_type;

endpackage

### src/bsc_dly.sv
// Fixed-depth delay line for payload that travels beside the pipeline.
module bsc_dly #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= data_in;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign data_out = tap_ff[DEPTH-1];

endmodule

### src/bsc_mul.sv
// Two-stage signed wide multiplier built from 33x33 limb products.
module bsc_mul #(
   parameter int unsigned A_W = 61,
   parameter int unsigned B_W = 34
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic signed [A_W-1:0]  a,
   input  logic signed [B_W-1:0]  b,
   output logic                   out_valid,
   output logic signed [A_W+B_W-1:0] product
);

   localparam int unsigned LW = bsc_pkg::LIMB_W;
   localparam int unsigned NA = (A_W + LW - 1) / LW;
   localparam int unsigned NB = (B_W + LW - 1) / LW;
   localparam int unsigned P_W = A_W + B_W;
   localparam int unsigned AX_W = NA * LW;
   localparam int unsigned BX_W = NB * LW;
   localparam int unsigned PP_W = 2 * LW + 2;

   logic signed [NA*LW-1:0]  a_ext;
   logic signed [NB*LW-1:0]  b_ext;
   logic signed [LW:0]       a_limb [NA];
   logic signed [LW:0]       b_limb [NB];
   logic signed [2*LW+1:0]   pp_ff  [NA][NB];
   logic signed [P_W-1:0]    sum_in;
   logic signed [P_W-1:0]    product_ff;
   logic                     v1_ff;
   logic                     v2_ff;

   assign a_ext = AX_W'(a);
   assign b_ext = BX_W'(b);

   // low limbs are unsigned, only the top limb carries the sign
   for (genvar i = 0; i < NA; i++) begin : g_al
      if (i == NA - 1) begin : g_top
         assign a_limb[i] = $signed({a_ext[LW*i+LW-1], a_ext[LW*i +: LW]});
      end else begin : g_low
         assign a_limb[i] = $signed({1'b0, a_ext[LW*i +: LW]});
      end
   end
   for (genvar j = 0; j < NB; j++) begin : g_bl
      if (j == NB - 1) begin : g_top
         assign b_limb[j] = $signed({b_ext[LW*j+LW-1], b_ext[LW*j +: LW]});
      end else begin : g_low
         assign b_limb[j] = $signed({1'b0, b_ext[LW*j +: LW]});
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_ff[i][j] <= PP_W'(a_limb[i]) * PP_W'(b_limb[j]);
         end
      end
      product_ff <= sum_in;
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            sum_in = sum_in + (P_W'(pp_ff[i][j]) <<< (LW * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign product   = product_ff;

endmodule

### src/baro_sensor_compensation.sv
// Top level: pipelined polynomial compensation of raw pressure and temperature.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------
//  request  | start / busy       | req_data  (raw_pressure, raw_temperature)
//  response | rsp_strobe         | rsp_data  (temperature_q16, pressure_q6, saturated)
//  config   | csr_we             | csr_index, csr_data
//
// One transaction enters per cycle while busy is low, and each gets its own response strobe.
// The response path runs through capture, three prep stages and the three chained Horner steps
// in tn (two multiplier stages and one add stage each), plus the output register.
// busy follows reset and is low otherwise: the pipeline never holds, and the
// receiver cannot stall it.
// Synchronous reset clears the valid chain and the calibration registers.
module baro_sensor_compensation (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bsc_pkg::req_type                  req_data,
   output logic                              rsp_strobe,
   output bsc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bsc_pkg::CSR_W-1:0]         csr_data
);

   localparam int unsigned TN_W = bsc_pkg::TN_W;
   localparam int unsigned H3_W = bsc_pkg::H3_W;
   localparam int unsigned H2_W = bsc_pkg::H2_W;
   localparam int unsigned H1_W = bsc_pkg::H1_W;
   localparam int unsigned H0_W = bsc_pkg::H0_W;
   localparam int unsigned B2_W = bsc_pkg::B2_W;
   localparam int unsigned B1_W = bsc_pkg::B1_W;
   localparam int unsigned B0_W = bsc_pkg::B0_W;
   localparam int unsigned Q_W  = H0_W - bsc_pkg::P_FRAC;

   // calibration registers
   logic [39:0] calib_temp_ff;
   logic [63:0] calib_press_a_ff;
   logic [63:0] calib_press_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_temp_ff    <= '0;
         calib_press_a_ff <= '0;
         calib_press_b_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bsc_pkg::CSR_CALIB_TEMP:    calib_temp_ff    <= csr_data[39:0];
            bsc_pkg::CSR_CALIB_PRESS_A: calib_press_a_ff <= csr_data;
            bsc_pkg::CSR_CALIB_PRESS_B: calib_press_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [15:0]        t1, t2, p5, p6;
   logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
   logic signed [15:0] p1, p2, p9;
   logic signed [16:0] p1m, p2m;

   assign t1  = calib_temp_ff[15:0];
   assign t2  = calib_temp_ff[31:16];
   assign t3  = calib_temp_ff[39:32];
   assign p1  = calib_press_a_ff[15:0];
   assign p2  = calib_press_a_ff[31:16];
   assign p3  = calib_press_a_ff[39:32];
   assign p4  = calib_press_a_ff[47:40];
   assign p5  = calib_press_a_ff[63:48];
   assign p6  = calib_press_b_ff[15:0];
   assign p7  = calib_press_b_ff[23:16];
   assign p8  = calib_press_b_ff[31:24];
   assign p9  = calib_press_b_ff[47:32];
   assign p10 = calib_press_b_ff[55:48];
   assign p11 = calib_press_b_ff[63:56];
   assign p1m = 17'(p1) - 17'sd16384;
   assign p2m = 17'(p2) - 17'sd16384;

   assign busy = reset;

   // stage 0: capture the transaction
   logic        v0_ff;
   logic [23:0] u0_ff, ut0_ff;

   always_ff @(posedge clock) begin
      u0_ff  <= req_data.raw_pressure;
      ut0_ff <= req_data.raw_temperature;
   end

   // stage 1: temperature offset, u^2 and the single-u products
   logic signed [24:0] d_in, d1_ff;
   logic [47:0]        u2_in, u2_1_ff;
   logic [23:0]        u1_ff;
   logic signed [32:0] mp4_in, mp4_1_ff, mp3_in, mp3_1_ff;
   logic signed [41:0] mp2_in, mp2_1_ff, mp2_2_ff, mp1_in, mp1_1_ff, mp1_2_ff, mp1_3_ff;

   assign d_in   = $signed({1'b0, ut0_ff}) - $signed({1'b0, t1, 8'd0});
   assign u2_in  = 48'(u0_ff) * 48'(u0_ff);
   assign mp4_in = 33'(p4) * 33'($signed({1'b0, u0_ff}));
   assign mp3_in = 33'(p3) * 33'($signed({1'b0, u0_ff}));
   assign mp2_in = 42'(p2m) * 42'($signed({1'b0, u0_ff}));
   assign mp1_in = 42'(p1m) * 42'($signed({1'b0, u0_ff}));

   always_ff @(posedge clock) begin
      d1_ff    <= d_in;
      u1_ff    <= u0_ff;
      u2_1_ff  <= u2_in;
      mp4_1_ff <= mp4_in;
      mp3_1_ff <= mp3_in;
      mp2_1_ff <= mp2_in;
      mp1_1_ff <= mp1_in;
   end

   // stage 2: temperature products, cubic and quadratic coefficients, u^2 and u^3 products
   logic signed [41:0]   dt2_in, dt2_2_ff;
   logic signed [49:0]   dd_in, dd_2_ff;
   logic signed [H3_W-1:0] h3_in, h3_2_ff, h3_3_ff;
   logic signed [B2_W-1:0] b2_in, b2_2_ff, b2_5;
   logic signed [56:0]   mp10_in, mp10_2_ff;
   logic signed [64:0]   mp9_in, mp9_2_ff, mp9_3_ff;
   logic [71:0]          u3_in, u3_2_ff;

   assign dt2_in  = 42'(d1_ff) * 42'($signed({1'b0, t2}));
   assign dd_in   = 50'(d1_ff) * 50'(d1_ff);
   assign h3_in   = (H3_W'(p8) <<< 22) + H3_W'(mp4_1_ff);
   assign b2_in   = (B2_W'(p7) <<< 24) + B2_W'(mp3_1_ff);
   assign mp10_in = 57'(p10) * 57'($signed({1'b0, u2_1_ff}));
   assign mp9_in  = 65'(p9) * 65'($signed({1'b0, u2_1_ff}));
   assign u3_in   = 72'(u2_1_ff) * 72'(u1_ff);

   always_ff @(posedge clock) begin
      dt2_2_ff  <= dt2_in;
      dd_2_ff   <= dd_in;
      h3_2_ff   <= h3_in;
      b2_2_ff   <= b2_in;
      mp10_2_ff <= mp10_in;
      mp9_2_ff  <= mp9_in;
      u3_2_ff   <= u3_in;
      mp2_2_ff  <= mp2_1_ff;
      mp1_2_ff  <= mp1_1_ff;
   end

   // stage 3: linearized temperature tn = t * 2^48, linear-in-tn coefficient
   logic signed [TN_W-1:0] ddt3, tn_in, tn_3_ff, tn_6, tn_9;
   logic signed [B1_W-1:0] b1_in, b1_3_ff, b1_8;
   logic signed [80:0]     mp11_in, mp11_3_ff;

   assign ddt3    = TN_W'(dd_2_ff) * TN_W'(t3);
   assign tn_in   = (TN_W'(dt2_2_ff) <<< 18) + ddt3;
   assign mp11_in = 81'(p11) * 81'($signed({1'b0, u3_2_ff}));
   assign b1_in   = (B1_W'({1'b0, p6}) << 42) + (B1_W'(mp2_2_ff) <<< 19)
                  + B1_W'(mp10_2_ff);

   always_ff @(posedge clock) begin
      tn_3_ff   <= tn_in;
      b1_3_ff   <= b1_in;
      mp11_3_ff <= mp11_in;
      mp9_3_ff  <= mp9_2_ff;
      mp1_3_ff  <= mp1_2_ff;
      h3_3_ff   <= h3_2_ff;
   end

   // stage 4: constant coefficient and rounded temperature
   logic signed [B0_W-1:0] b0_in, b0_4_ff, b0_11;
   logic signed [61:0]     tsum;
   logic signed [29:0]     tq;
   logic                   tsat_in;
   logic signed [23:0]     tq_in;
   logic [24:0]            temp_4_ff, temp_12;

   assign b0_in = (B0_W'({1'b0, p5}) << 68) + (B0_W'(mp1_3_ff) <<< 45)
                + (B0_W'(mp9_3_ff) <<< 17) + B0_W'(mp11_3_ff);
   assign tsum  = 62'(tn_3_ff) + 62'sd2147483648;
   assign tq    = tsum[61:32];

   always_comb begin
      tsat_in = 1'b0;
      tq_in   = tq[23:0];
      if (tq > 30'sd8388607) begin
         tq_in   = 24'sh7FFFFF;
         tsat_in = 1'b1;
      end else if (tq < -30'sd8388608) begin
         tq_in   = 24'sh800000;
         tsat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      b0_4_ff   <= b0_in;
      temp_4_ff <= {tsat_in, tq_in};
   end

   // side delays aligning the coefficients, tn and the temperature result with the Horner chain
   bsc_dly #(.WIDTH(B2_W), .DEPTH(3)) u_dly_b2 (
      .clock(clock), .data_in(b2_2_ff), .data_out(b2_5));
   bsc_dly #(.WIDTH(TN_W), .DEPTH(3)) u_dly_tn6 (
      .clock(clock), .data_in(tn_3_ff), .data_out(tn_6));
   bsc_dly #(.WIDTH(TN_W), .DEPTH(3)) u_dly_tn9 (
      .clock(clock), .data_in(tn_6), .data_out(tn_9));
   bsc_dly #(.WIDTH(B1_W), .DEPTH(5)) u_dly_b1 (
      .clock(clock), .data_in(b1_3_ff), .data_out(b1_8));
   bsc_dly #(.WIDTH(B0_W), .DEPTH(7)) u_dly_b0 (
      .clock(clock), .data_in(b0_4_ff), .data_out(b0_11));
   bsc_dly #(.WIDTH(25), .DEPTH(8)) u_dly_temp (
      .clock(clock), .data_in(temp_4_ff), .data_out(temp_12));

   // valid chain up to the first multiplier
   logic v1_ff, v2_ff, v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Horner step 1: H2 = B2*2^53 + tn*H3
   logic                          v5, v6_ff, v8, v9_ff, v11, v12_ff;
   logic signed [TN_W+H3_W-1:0]   prod3;
   logic signed [H2_W-1:0]        h2_6_ff;
   logic signed [TN_W+H2_W-1:0]   prod2;
   logic signed [H1_W-1:0]        h1_9_ff;
   logic signed [TN_W+H1_W-1:0]   prod1;
   logic signed [H0_W-1:0]        h0_12_ff;

   bsc_mul #(.A_W(TN_W), .B_W(H3_W)) u_mul3 (
      .clock(clock), .reset(reset), .in_valid(v3_ff),
      .a(tn_3_ff), .b(h3_3_ff), .out_valid(v5), .product(prod3));

   always_ff @(posedge clock) begin
      h2_6_ff <= (H2_W'(b2_5) <<< bsc_pkg::B2_SHIFT) + H2_W'(prod3);
   end

   // Horner step 2: H1 = B1*2^85 + tn*H2
   bsc_mul #(.A_W(TN_W), .B_W(H2_W)) u_mul2 (
      .clock(clock), .reset(reset), .in_valid(v6_ff),
      .a(tn_6), .b(h2_6_ff), .out_valid(v8), .product(prod2));

   always_ff @(posedge clock) begin
      h1_9_ff <= (H1_W'(b1_8) <<< bsc_pkg::B1_SHIFT) + H1_W'(prod2);
   end

   // Horner step 3: H0 = B0*2^116 + tn*H1, pressure * 2^181
   bsc_mul #(.A_W(TN_W), .B_W(H1_W)) u_mul1 (
      .clock(clock), .reset(reset), .in_valid(v9_ff),
      .a(tn_9), .b(h1_9_ff), .out_valid(v11), .product(prod1));

   always_ff @(posedge clock) begin
      h0_12_ff <= (H0_W'(b0_11) <<< bsc_pkg::B0_SHIFT) + H0_W'(prod1);
   end

   // round to 1/64 Pa, ties up, then clamp
   logic signed [H0_W-1:0] prnd;
   logic signed [Q_W-1:0]  pq;
   logic [23:0]            press_in;
   logic                   psat_in;
   bsc_pkg::rsp_type       rsp_in, rsp_ff;
   logic                   rsp_strobe_ff;

   assign prnd = h0_12_ff + (H0_W'(1) << (bsc_pkg::P_FRAC - 1));
   assign pq   = prnd[H0_W-1:bsc_pkg::P_FRAC];

   always_comb begin
      press_in = pq[23:0];
      psat_in  = 1'b0;
      if (pq[Q_W-1]) begin
         press_in = '0;
         psat_in  = 1'b1;
      end else if (pq[Q_W-2:24] != '0) begin
         press_in = '1;
         psat_in  = 1'b1;
      end
      rsp_in.temperature_q16 = temp_12[23:0];
      rsp_in.pressure_q6     = press_in;
      rsp_in.saturated       = psat_in | temp_12[24];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff         <= 1'b0;
         v9_ff         <= 1'b0;
         v12_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v6_ff         <= v5;
         v9_ff         <= v8;
         v12_ff        <= v11;
         rsp_strobe_ff <= v12_ff;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### src/bsc_checker.sv
// Port-level checks of the compensation block, bound to its top level.
module bsc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input bsc_pkg::rsp_type rsp_data
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("response strobe right after reset");

   // every accepted transaction answers after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(bsc_pkg::LATENCY) rsp_strobe)
      else $error("response missing after accepted transaction");

   // no response without an accepted transaction
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, bsc_pkg::LATENCY))
      else $error("response without a transaction");

   // unclamped values never carry the saturation flag
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.pressure_q6 != 24'h000000
       && rsp_data.pressure_q6 != 24'hFFFFFF
       && rsp_data.temperature_q16 != 24'sh7FFFFF
       && rsp_data.temperature_q16 != 24'sh800000) |-> !rsp_data.saturated)
      else $error("saturation flag on an in-range result");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_strobe(rsp_strobe),
   .rsp_data(rsp_data)
);

### sim/baro_sensor_compensation_tb.sv
// Self-checking testbench for the barometric sensor compensation pipeline.
module baro_sensor_compensation_tb;

   localparam logic [bsc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned STALL_LIMIT = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   bsc_pkg::req_type req_data = '0;
   logic rsp_strobe;
   bsc_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [bsc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bsc_pkg::CSR_W-1:0] csr_data = '0;

   // local copy of the calibration registers
   logic [39:0] calib_temp_q;
   logic [63:0] calib_press_a_q;
   logic [63:0] calib_press_b_q;

   bsc_pkg::rsp_type compensated_q[$];
   int unsigned mismatch_count = 0;
   int unsigned idle_pct = 0;
   int unsigned quiet_cycles = 0;

   baro_sensor_compensation dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [255:0] poly_term(logic signed [255:0] coef,
         logic signed [255:0] u, int unsigned up, logic signed [255:0] tn,
         int unsigned tp, int unsigned shift);
      logic signed [255:0] x;
      x = coef;
      repeat (up) x = x * u;
      repeat (tp) x = x * tn;
      return x <<< shift;
   endfunction

   function automatic bsc_pkg::rsp_type compensate(bsc_pkg::req_type r);
      bsc_pkg::rsp_type res;
      longint d, tn, tq;
      logic signed [7:0] t3, p3, p4, p7, p8, p10, p11;
      logic signed [15:0] p1, p2, p9;
      logic signed [255:0] u, tw, acc;
      t3 = calib_temp_q[39:32];
      p1 = calib_press_a_q[15:0];
      p2 = calib_press_a_q[31:16];
      p3 = calib_press_a_q[39:32];
      p4 = calib_press_a_q[47:40];
      p7 = calib_press_b_q[23:16];
      p8 = calib_press_b_q[31:24];
      p9 = calib_press_b_q[47:32];
      p10 = calib_press_b_q[55:48];
      p11 = calib_press_b_q[63:56];
      res.saturated = 1'b0;
      d = longint'(r.raw_temperature) - 256 * longint'(calib_temp_q[15:0]);
      tn = d * longint'(calib_temp_q[31:16]) * 262144 + d * d * longint'(t3);
      tq = (tn + 64'sd2147483648) >>> 32;
      if (tq > 8388607) begin
         tq = 8388607;
         res.saturated = 1'b1;
      end else if (tq < -8388608) begin
         tq = -8388608;
         res.saturated = 1'b1;
      end
      res.temperature_q16 = tq[23:0];
      u = {232'd0, r.raw_pressure};
      tw = tn;
      acc = poly_term({240'd0, calib_press_a_q[63:48]}, u, 0, tw, 0, 184);
      acc += poly_term({240'd0, calib_press_b_q[15:0]}, u, 0, tw, 1, 127);
      acc += poly_term(p7, u, 0, tw, 2, 77);
      acc += poly_term(p8, u, 0, tw, 3, 22);
      acc += poly_term(256'(p1) - 256'sd16384, u, 1, tw, 0, 161);
      acc += poly_term(256'(p2) - 256'sd16384, u, 1, tw, 1, 104);
      acc += poly_term(p3, u, 1, tw, 2, 53);
      acc += poly_term(p4, u, 1, tw, 3, 0);
      acc += poly_term(p9, u, 2, tw, 0, 133);
      acc += poly_term(p10, u, 2, tw, 1, 85);
      acc += poly_term(p11, u, 3, tw, 0, 116);
      // round to 1/64 Pa, ties toward plus infinity
      acc = (acc + (256'sd1 <<< 174)) >>> 175;
      if (acc < 0) begin
         res.pressure_q6 = '0;
         res.saturated = 1'b1;
      end else if (acc > 256'sd16777215) begin
         res.pressure_q6 = '1;
         res.saturated = 1'b1;
      end else begin
         res.pressure_q6 = acc[23:0];
      end
      return res;
   endfunction

   // check every response against the oldest prediction
   always @(posedge clock) begin
      bsc_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (compensated_q.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            mismatch_count++;
         end else begin
            want = compensated_q.pop_front();
            if (rsp_data.temperature_q16 !== want.temperature_q16) begin
               $error("temperature_q16 expected %0d actual %0d",
                      want.temperature_q16, rsp_data.temperature_q16);
               mismatch_count++;
            end
            if (rsp_data.pressure_q6 !== want.pressure_q6) begin
               $error("pressure_q6 expected %0d actual %0d",
                      want.pressure_q6, rsp_data.pressure_q6);
               mismatch_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated expected %0b actual %0b", want.saturated, rsp_data.saturated);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_sample(logic [23:0] press, logic [23:0] temp);
      start <= 1'b1;
      req_data <= '{raw_pressure: press, raw_temperature: temp};
      do @(posedge clock); while (busy);
      compensated_q.push_back(compensate('{raw_pressure: press, raw_temperature: temp}));
      // idle each following cycle with the set likelihood
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (compensated_q.size() != 0) @(posedge clock);
      repeat (bsc_pkg::LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_csr(logic [bsc_pkg::CSR_IDX_W-1:0] idx, logic [63:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         bsc_pkg::CSR_CALIB_TEMP: calib_temp_q = value[39:0];
         bsc_pkg::CSR_CALIB_PRESS_A: calib_press_a_q = value;
         bsc_pkg::CSR_CALIB_PRESS_B: calib_press_b_q = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_calibration(logic [39:0] ct, logic [63:0] pa, logic [63:0] pb);
      drain();
      write_csr(bsc_pkg::CSR_CALIB_TEMP, {24'd0, ct});
      write_csr(bsc_pkg::CSR_CALIB_PRESS_A, pa);
      write_csr(bsc_pkg::CSR_CALIB_PRESS_B, pb);
   endtask

   // plausible coefficient set: t1 t2 t3 / p1..p5 / p6..p11
   function automatic logic [191:0] typical_calibration();
      logic [39:0] ct;
      logic [63:0] pa, pb;
      ct = {8'(-($urandom_range(12, 2))), 16'($urandom_range(20000, 17000)),
            16'($urandom_range(28500, 26500))};
      pa = {16'($urandom_range(28000, 25000)), 8'($urandom_range(3)), 8'(-($urandom_range(12))),
            16'(-($urandom_range(5000))), 16'($urandom_range(400)) - 16'd2000};
      pb = {8'(-($urandom_range(60))), 8'($urandom_range(40)), 16'($urandom_range(8000, 4000)),
            8'(-($urandom_range(12))), 8'(-($urandom_range(12))), 16'($urandom_range(30000, 27000))};
      return {24'd0, ct, pa, pb};
   endfunction

   task automatic test_reset_defaults;
      send_sample('0, '0);
      send_sample('1, '1);
      send_sample(24'h800000, 24'h7FFFFF);
   endtask

   task automatic test_directed;
      logic [191:0] c;
      c = typical_calibration();
      load_calibration(c[167:128], c[127:64], c[63:0]);
      // values around the sensor's normal operating point
      send_sample(24'd6500000, {c[143:128], 8'h00});
      send_sample(24'd7000000, {c[143:128], 8'h00} + 24'd300000);
      send_sample(24'd6000000, {c[143:128], 8'h00} - 24'd300000);
      send_sample('0, '0);
      send_sample('1, '1);
      send_sample('0, '1);
      send_sample('1, '0);
      send_sample(24'h555555, 24'hAAAAAA);
      send_sample(24'hAAAAAA, 24'h555555);
      // ignored register index leaves the calibration untouched
      drain();
      write_csr(CSR_UNUSED, '1);
      send_sample(24'd6500000, {c[143:128], 8'h00});
      // extreme coefficients drive both outputs into their clamps
      load_calibration('1, '1, '1);
      send_sample('0, '0);
      send_sample('1, '1);
      send_sample(24'h123456, 24'hFEDCBA);
      load_calibration({8'h7F, 16'hFFFF, 16'h0000}, 64'h0000_7F7F_0000_0000,
                       64'h7F7F_7FFF_7F7F_FFFF);
      send_sample('1, '1);
      send_sample('0, '1);
      load_calibration({8'h80, 16'hFFFF, 16'hFFFF}, 64'h0000_8080_8000_8000,
                       64'h8080_8000_8080_0000);
      send_sample('1, '0);
      send_sample('1, '1);
      load_calibration('0, '0, '0);
      send_sample('1, '1);
   endtask

   task automatic test_random(int unsigned n);
      logic [191:0] c;
      logic [23:0] base;
      for (int unsigned i = 0; i < n; i++) begin
         if (i % 60 == 0) begin
            c = typical_calibration();
            if ($urandom_range(3) == 0) begin
               c[167:0] = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            end
            load_calibration(c[167:128], c[127:64], c[63:0]);
         end
         base = {c[143:128], 8'h00};
         if ($urandom_range(9) < 8) begin
            send_sample(24'($urandom_range(9000000, 3000000)),
                        base + 24'($urandom_range(1 << 20)) - 24'(1 << 19));
         end else begin
            send_sample(24'($urandom), 24'($urandom));
         end
      end
   endtask

   initial begin
      calib_temp_q = '0;
      calib_press_a_q = '0;
      calib_press_b_q = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_pct = 28;
      test_reset_defaults();
      test_directed();
      test_random(240);
      idle_pct = 64;
      test_random(240);
      idle_pct = 0;
      test_random(240);
      drain();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
